>>> hdl/asrl_pkg.sv
// Package for the address-to-symbol range lookup block.
// Holds field widths, operation and status codes, and table defaults.
// No dependencies.
package asrl_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 64;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 10;

    localparam int RES_BITS    = IDX_W + 2 * ADDR_W;
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - RES_BITS;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

endpackage

>>> hdl/asrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module asrl_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/address_to_symbol_range_lookup.sv
// Top level of the address-to-symbol range lookup block.
// Depends on asrl_pkg and asrl_ram.
//
// Usage: one input stream carries commands (s_tuser = operation, s_tdata = address),
// one output stream returns exactly one result per command, in order.
// Append stores the address at the end of the start-address table (status full when
// the table holds TABLE_DEPTH entries), clear empties it, lookup returns the index of
// the entry holding the address, the offset into it and the span to the next entry.
// Append, clear and unused codes give their result in the cycle after acceptance.
// A lookup reads the table RAM once per cycle through its single read port: when every
// append so far was in ascending order it bisects; once an out-of-order append happened
// it scans upward, until the next clear.
// One command is in flight at a time; s_tready stays low while a lookup runs and while
// a finished result waits and m_tready is low. The result register holds its
// transaction until taken.
// Reset empties the table at once (no clearing pass) and drops any pending result.
module address_to_symbol_range_lookup #(
    parameter int unsigned TABLE_DEPTH = asrl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [asrl_pkg::ADDR_W-1:0]         s_tdata,   // [63:0] address
    input  logic [asrl_pkg::OP_W-1:0]           s_tuser,   // [1:0] operation
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [asrl_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [9:0] entry_index,
                                                           // [73:10] offset,
                                                           // [137:74] span, rest 0
    output logic [asrl_pkg::STAT_W-1:0]         m_tuser    // [1:0] status
);

    import asrl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRST = 4'b0010,
        S_CMP   = 4'b0100,
        S_BASE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic sorted_reg, sorted_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [ADDR_W-1:0] nxt_reg, nxt_next;

    logic out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [ADDR_W-1:0] out_off_reg, out_off_next;
    logic [ADDR_W-1:0] out_span_reg, out_span_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [ADDR_W-1:0] ram_rdata;

    // search step
    logic do_step;
    logic [CW-1:0] step_lo, step_hi, step_mid, step_base;
    logic [CW:0] step_sum;
    logic greater;

    // result staging
    logic res_load;
    logic [STAT_W-1:0] res_status;
    logic [IDX_W-1:0] res_idx;
    logic [ADDR_W-1:0] res_off, res_span;
    logic [ADDR_W-1:0] base_off;
    logic [CW-1:0] lo_m1;
    logic [CW+IDX_W-1:0] idx_ext;

    asrl_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign step_sum  = {1'b0, step_lo} + {1'b0, step_hi};
    assign step_mid  = sorted_reg ? step_sum[CW:1] : step_lo;
    assign step_base = step_lo - ONE_C;
    assign greater   = ram_rdata > addr_reg;
    assign base_off  = addr_reg - ram_rdata;
    assign lo_m1     = lo_reg - ONE_C;
    assign idx_ext   = {{IDX_W{1'b0}}, lo_m1};

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        last_next   = last_reg;
        addr_next   = addr_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        nxt_next    = nxt_reg;

        ram_we    = 1'b0;
        ram_waddr = count_reg[AW-1:0];
        ram_wdata = s_tdata;
        ram_raddr = '0;

        do_step = 1'b0;
        step_lo = ONE_C;
        step_hi = count_reg;

        res_load   = 1'b0;
        res_status = STAT_MISS;
        res_idx    = '0;
        res_off    = '0;
        res_span   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (s_tuser)
                        OP_APPEND: begin
                            res_load = 1'b1;
                            if (count_reg == DEPTH_C) begin
                                res_status = STAT_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + ONE_C;
                                if (count_reg != '0 && s_tdata < last_reg) begin
                                    sorted_next = 1'b0;
                                end
                                last_next  = s_tdata;
                                res_status = STAT_OK;
                            end
                        end
                        OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_load = 1'b1;
                            end else begin
                                addr_next  = s_tdata;
                                ram_raddr  = '0;
                                state_next = S_FIRST;
                            end
                        end
                        OP_CLEAR: begin
                            count_next  = '0;
                            sorted_next = 1'b1;
                            res_load    = 1'b1;
                            res_status  = STAT_OK;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            S_FIRST: begin
                if (addr_reg < ram_rdata) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    do_step = 1'b1;
                end
            end
            S_CMP: begin
                do_step = 1'b1;
                if (greater) begin
                    step_lo  = lo_reg;
                    step_hi  = mid_reg;
                    nxt_next = ram_rdata;
                end else begin
                    step_lo = mid_reg + ONE_C;
                    step_hi = hi_reg;
                end
            end
            S_BASE: begin
                res_load   = 1'b1;
                state_next = S_IDLE;
                if (base_off != '0) begin
                    res_status = STAT_OK;
                    res_idx    = idx_ext[IDX_W-1:0];
                    res_off    = base_off;
                    res_span   = nxt_reg - ram_rdata;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_step) begin
            lo_next = step_lo;
            hi_next = step_hi;
            if (step_lo < step_hi) begin
                ram_raddr  = step_mid[AW-1:0];
                mid_next   = step_mid;
                state_next = S_CMP;
            end else if (step_lo == count_reg) begin
                res_load   = 1'b1;
                state_next = S_IDLE;
            end else begin
                ram_raddr  = step_base[AW-1:0];
                state_next = S_BASE;
            end
        end

        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_off_next    = out_off_reg;
        out_span_next   = out_span_reg;
        if (res_load) begin
            out_valid_next  = 1'b1;
            out_status_next = res_status;
            out_idx_next    = res_idx;
            out_off_next    = res_off;
            out_span_next   = res_span;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sorted_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg       <= last_next;
        addr_reg       <= addr_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        nxt_reg        <= nxt_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_off_reg    <= out_off_next;
        out_span_reg   <= out_span_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_span_reg, out_off_reg, out_idx_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input accepted during lookup");

    a_probe_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (mid_reg < count_reg) && (lo_reg <= mid_reg)
            && (mid_reg < hi_reg))
        else $error("search probe outside table");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero payload on non-hit result");

endmodule

>>> dv/tb.sv
// Self-checking testbench for address_to_symbol_range_lookup: appends, clears and lookups
// on start-address tables, both ascending and out of order, checked against a local predictor.
// Depends on asrl_pkg and the RTL top level.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asrl_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] span;
    } range_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = OP_CLEAR;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]      m_tuser;

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    range_result_t     pending_results[$];
    range_result_t     oldest_result;
    logic [ADDR_W-1:0] start_model[TABLE_DEPTH_DEF];
    int unsigned       entries_held;
    int unsigned       failures, items_sent, cycle_count;
    int unsigned       n_append, n_lookup, n_hit, n_full;

    address_to_symbol_range_lookup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 aclk = ~aclk;

    // expected result of one command, with the table copy updated in step
    function automatic void predict_range(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        range_result_t r;
        r = '0;
        r.status = STAT_MISS;
        case (op)
            OP_APPEND: begin
                n_append++;
                if (entries_held >= TABLE_DEPTH_DEF) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    start_model[entries_held] = addr;
                    entries_held++;
                    r.status = STAT_OK;
                end
            end
            OP_LOOKUP: begin
                n_lookup++;
                if (entries_held != 0 && addr >= start_model[0]) begin
                    for (int unsigned k = 1; k < entries_held; k++) begin
                        if (start_model[k] > addr) begin
                            if (addr != start_model[k-1]) begin
                                r.status      = STAT_OK;
                                r.entry_index = IDX_W'(k - 1);
                                r.offset      = addr - start_model[k-1];
                                r.span        = start_model[k] - start_model[k-1];
                                n_hit++;
                            end
                            break;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                entries_held = 0;
                r.status = STAT_OK;
            end
            default: ;
        endcase
        pending_results.push_back(r);
    endfunction

    function automatic void check_field(input string what, input logic [ADDR_W-1:0] want,
                                        input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected none actual %h/%h",
                         $time, m_tuser, m_tdata);
                failures++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("status", ADDR_W'(oldest_result.status), ADDR_W'(m_tuser));
                check_field("entry_index", ADDR_W'(oldest_result.entry_index),
                            ADDR_W'(m_tdata[IDX_W-1:0]));
                check_field("offset", oldest_result.offset, m_tdata[IDX_W +: ADDR_W]);
                check_field("span", oldest_result.span, m_tdata[IDX_W+ADDR_W +: ADDR_W]);
                check_field("padding", '0, ADDR_W'(m_tdata[OUT_TDATA_W-1 -: PAD_W]));
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= !(sink_idle_on && $urandom_range(99) < 20);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results pending", $time, pending_results.size());
            $display("** address_to_symbol_range_lookup: FAILED **");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(1) == 0) v = v >> $urandom_range(63);
        return v;
    endfunction

    // one transaction on the command side; s_tvalid stays high after the handshake
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr);
        while (src_idle_on && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        predict_range(op, addr);
        items_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic load_table(input int unsigned n, input bit ascending, input bit dense,
                              output logic [ADDR_W-1:0] starts[$]);
        logic [ADDR_W-1:0] v;
        starts = {};
        for (int unsigned i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(9) == 0)
                v = starts[i-1];
            else if (dense)
                v = (i == 0) ? rand_addr() >> 1 : starts[i-1] + $urandom_range(1, 40);
            else
                v = rand_addr();
            starts.push_back(v);
        end
        if (ascending) starts.sort();
        foreach (starts[i]) send_cmd(OP_APPEND, starts[i]);
    endtask

    // lookup address near the interesting points of the loaded table
    function automatic logic [ADDR_W-1:0] pick_probe(input logic [ADDR_W-1:0] starts[$]);
        int unsigned       sel;
        int unsigned       k;
        logic [ADDR_W-1:0] gap;
        sel = $urandom_range(99);
        if (starts.size() == 0 || sel >= 85) return rand_addr();
        k = $urandom_range(starts.size() - 1);
        if (sel < 45 && k + 1 < starts.size()) begin
            gap = starts[k+1] - starts[k];
            if (gap == 0) return starts[k];
            if (sel < 35) return starts[k] + rand_addr() % gap;
            return starts[k+1] - 1;
        end
        if (sel < 60) return starts[k];
        if (sel < 70) return starts[k] + 1;
        if (sel < 78) return starts[0] - 1 - $urandom_range(3);
        return starts[starts.size()-1] + $urandom_range(3);
    endfunction

    task automatic test_directed();
        send_cmd(OP_LOOKUP, '0);
        send_cmd(OP_LOOKUP, '1);
        send_cmd(OP_UNUSED, '1);
        send_cmd(OP_CLEAR, '0);
        send_cmd(OP_APPEND, 64'h100);
        send_cmd(OP_APPEND, 64'h180);
        send_cmd(OP_APPEND, 64'h8000_0000_0000_0000);
        send_cmd(OP_APPEND, '1);
        send_cmd(OP_LOOKUP, '0);
        send_cmd(OP_LOOKUP, 64'hff);
        send_cmd(OP_LOOKUP, 64'h100);
        send_cmd(OP_LOOKUP, 64'h17f);
        send_cmd(OP_LOOKUP, 64'h180);
        send_cmd(OP_LOOKUP, 64'h7fff_ffff_ffff_ffff);
        send_cmd(OP_LOOKUP, 64'h8000_0000_0000_0001);
        send_cmd(OP_LOOKUP, 64'hffff_ffff_ffff_fffe);
        send_cmd(OP_LOOKUP, '1);
        // out-of-order append switches the table to upward scanning
        send_cmd(OP_APPEND, 64'h200);
        send_cmd(OP_LOOKUP, 64'h300);
        send_cmd(OP_LOOKUP, 64'h1ff);
        send_cmd(OP_LOOKUP, '1);
        send_cmd(OP_CLEAR, '1);
        send_cmd(OP_LOOKUP, 64'h100);
        wait_drain();
    endtask

    task automatic test_full_table();
        logic [ADDR_W-1:0] starts[$];
        logic [ADDR_W-1:0] v;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_cmd(OP_CLEAR, '0);
        v = rand_addr() >> 2;
        repeat (TABLE_DEPTH_DEF) begin
            starts.push_back(v);
            send_cmd(OP_APPEND, v);
            v = v + 1 + ({$urandom, $urandom} >> $urandom_range(20, 60));
        end
        repeat (12) send_cmd(OP_LOOKUP, pick_probe(starts));
        send_cmd(OP_LOOKUP, starts[TABLE_DEPTH_DEF-2] + 1);
        send_cmd(OP_LOOKUP, starts[TABLE_DEPTH_DEF-1] - 1);
        send_cmd(OP_LOOKUP, starts[TABLE_DEPTH_DEF-1]);
        send_cmd(OP_APPEND, '1);
        send_cmd(OP_APPEND, rand_addr());
        send_cmd(OP_UNUSED, rand_addr());
        send_cmd(OP_LOOKUP, starts[511] + 1);
        send_cmd(OP_CLEAR, rand_addr());
        send_cmd(OP_LOOKUP, starts[511] + 1);
        wait_drain();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    task automatic run_random_rounds(input int unsigned item_budget, input bit ascending);
        logic [ADDR_W-1:0] starts[$];
        logic [ADDR_W-1:0] v;
        int unsigned       stop_at;
        int unsigned       n;
        int unsigned       pick;
        stop_at = items_sent + item_budget;
        while (items_sent < stop_at) begin
            src_idle_on  = ($urandom_range(4) != 0);
            sink_idle_on = ($urandom_range(4) != 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            send_cmd(OP_CLEAR, rand_addr());
            load_table(n, ascending, 1'($urandom_range(1)), starts);
            repeat ($urandom_range(5, 30)) begin
                pick = $urandom_range(99);
                if (pick < 88) begin
                    send_cmd(OP_LOOKUP, pick_probe(starts));
                end else if (pick < 92) begin
                    send_cmd(OP_UNUSED, rand_addr());
                end else if (pick < 96) begin
                    v = rand_addr();
                    send_cmd(OP_APPEND, v);
                    starts.push_back(v);
                end else begin
                    send_cmd(OP_CLEAR, rand_addr());
                    starts = {};
                end
            end
            if ($urandom_range(3) == 0) wait_drain();
        end
        wait_drain();
    endtask

    task automatic test_random_ascending();
        run_random_rounds(170, 1'b1);
    endtask

    task automatic test_random_unordered();
        run_random_rounds(90, 1'b0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        test_random_ascending();
        test_random_unordered();
        repeat (10) @(posedge aclk);
        $display("Ran %0d commands: %0d appends (%0d table full), %0d lookups (%0d hits).",
                 items_sent, n_append, n_full, n_lookup, n_hit);
        $display("Tables from empty to %0d entries, ascending and out of order.",
                 TABLE_DEPTH_DEF);
        if (failures == 0) begin
            $display("** address_to_symbol_range_lookup: PASSED **");
        end else begin
            $display("** address_to_symbol_range_lookup: FAILED **");
        end
        $finish;
    end

endmodule
